FILE: rtl/gap_pkg.sv
// gap_pkg: shared types, widths and constants for the global average pool unit.
// No dependencies; imported by every module under rtl/.
`timescale 1ns / 1ps

package gap_pkg;

    // Field and state widths
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 32;
    localparam int POS_W      = 17;
    localparam int CNT_W      = 17;
    localparam int LANE_W     = 2;
    localparam int LANE_SLOTS = 4;
    localparam int LCNT_W     = 3;
    localparam int STEP_W     = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] REG_LANE_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SIZE = 1'b1;

    // Lane mode codes; any other code means four lanes
    localparam logic [1:0] MODE_ONE = 2'd0;
    localparam logic [1:0] MODE_TWO = 2'd1;

    // floor(x / 3) = (x * DIV3_RECIP) >> DIV3_SHIFT, exact for x < 2^19
    localparam logic [17:0] DIV3_RECIP = 18'd174763;
    localparam int          DIV3_SHIFT = 19;

    // Job queue between front and back
    localparam int JOB_DEPTH = 2;

    // One finished channel: per-lane sums and the divisor
    typedef struct packed {
        logic [LANE_SLOTS-1:0][SUM_W-1:0] sums;
        logic [LCNT_W-1:0]                lanes;
        logic [CNT_W-1:0]                 per_lane;
    } job_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_HOLD
    } back_state_t;

    // Apply sign to a quotient magnitude and clamp to the signed 16-bit range
    function automatic logic [SAMPLE_W-1:0] saturate_q(input logic [SUM_W-1:0] mag,
                                                        input logic neg);
        logic [SAMPLE_W-1:0] res;
        if (!neg) begin
            res = (mag > 32'd32767) ? 16'h7FFF : mag[SAMPLE_W-1:0];
        end else begin
            res = (mag > 32'd32768) ? 16'h8000 : (~mag[SAMPLE_W-1:0] + 16'd1);
        end
        return res;
    endfunction

endpackage

FILE: rtl/gap_front.sv
// gap_front: configuration registers, per-lane accumulation and channel-end detection.
// Depends on gap_pkg; pushes one job_t per finished channel into the job queue.
`timescale 1ns / 1ps

module gap_front
    import gap_pkg::*;
#(
    parameter int MAX_CHANNEL_ELEMS = 65536,
    parameter int MAX_LANES         = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // sample stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,
    // job queue
    input  logic                  fifo_full,
    output logic                  push,
    output job_t                  push_job
);

    logic [1:0]                        lane_mode_reg, lane_mode_next;
    logic [POS_W-1:0]                  channel_size_reg, channel_size_next;
    logic [LCNT_W-1:0]                 lanes_reg, lanes_next, lanes_raw;
    logic [POS_W-1:0]                  size_reg, size_next;
    logic [CNT_W-1:0]                  per_lane_reg, per_lane_next;
    logic [POS_W-1:0]                  full_reg, full_next;
    logic [34:0]                       prod3;
    logic [POS_W-1:0]                  position_reg, position_next;
    logic [1:0]                        pos_mod3_reg, pos_mod3_next;
    logic [LANE_SLOTS-1:0][SUM_W-1:0]  sums_reg, sums_next, sums_upd;
    logic [LANE_W-1:0]                 lane_mask, lane_sel;
    logic                              in_range, at_end, accept;
    logic [SUM_W-1:0]                  ext;

    assign cfg_ready = 1'b1;
    assign s_tready  = !fifo_full;
    assign accept    = s_tvalid && s_tready;

    // Register writes
    always_comb begin
        lane_mode_next    = lane_mode_reg;
        channel_size_next = channel_size_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_LANE_MODE:    lane_mode_next    = cfg_data[1:0];
                REG_CHANNEL_SIZE: channel_size_next = cfg_data[POS_W-1:0];
                default:          lane_mode_next    = lane_mode_reg;
            endcase
        end
    end

    // Derived settings, registered so the sample path sees no multiplier
    always_comb begin
        unique case (lane_mode_next)
            MODE_ONE: lanes_raw = 3'd1;
            MODE_TWO: lanes_raw = 3'd2;
            default:  lanes_raw = 3'd4;
        endcase
        lanes_next = (lanes_raw > LCNT_W'(MAX_LANES)) ? LCNT_W'(MAX_LANES) : lanes_raw;

        if (channel_size_next == '0) begin
            size_next = POS_W'(1);
        end else if ({15'b0, channel_size_next} > 32'(MAX_CHANNEL_ELEMS)) begin
            size_next = POS_W'(MAX_CHANNEL_ELEMS);
        end else begin
            size_next = channel_size_next;
        end

        prod3 = {18'b0, size_next} * {17'b0, DIV3_RECIP};

        case (lanes_next)
            3'd1:    per_lane_next = size_next;
            3'd2:    per_lane_next = {1'b0, size_next[POS_W-1:1]};
            3'd3:    per_lane_next = {1'b0, prod3[34:DIV3_SHIFT]};
            default: per_lane_next = {2'b0, size_next[POS_W-1:2]};
        endcase

        case (lanes_next)
            3'd1:    full_next = per_lane_next;
            3'd2:    full_next = {per_lane_next[CNT_W-2:0], 1'b0};
            3'd3:    full_next = per_lane_next + {per_lane_next[CNT_W-2:0], 1'b0};
            default: full_next = {per_lane_next[CNT_W-3:0], 2'b0};
        endcase
    end

    // Accumulate into the sample's lane; detect channel end
    always_comb begin
        lane_mask = lanes_reg[LANE_W-1:0] - 2'd1;
        lane_sel  = (lanes_reg == 3'd3) ? pos_mod3_reg : (position_reg[LANE_W-1:0] & lane_mask);
        in_range  = position_reg < full_reg;
        ext       = {{(SUM_W-SAMPLE_W){s_tdata[SAMPLE_W-1]}}, s_tdata};
        at_end    = ({1'b0, position_reg} + 18'd1) >= {1'b0, size_reg};

        sums_upd = sums_reg;
        if (in_range) begin
            sums_upd[lane_sel] = sums_reg[lane_sel] + ext;
        end

        sums_next     = sums_reg;
        position_next = position_reg;
        pos_mod3_next = pos_mod3_reg;
        if (accept) begin
            if (at_end) begin
                sums_next     = '0;
                position_next = '0;
                pos_mod3_next = '0;
            end else begin
                sums_next     = sums_upd;
                position_next = position_reg + POS_W'(1);
                pos_mod3_next = (pos_mod3_reg == 2'd2) ? 2'd0 : pos_mod3_reg + 2'd1;
            end
        end

        push              = accept && at_end;
        push_job.sums     = sums_upd;
        push_job.lanes    = lanes_reg;
        push_job.per_lane = per_lane_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_mode_reg    <= MODE_ONE;
            channel_size_reg <= POS_W'(1);
            lanes_reg        <= LCNT_W'(1);
            size_reg         <= POS_W'(1);
            per_lane_reg     <= CNT_W'(1);
            full_reg         <= POS_W'(1);
            position_reg     <= '0;
            pos_mod3_reg     <= '0;
            sums_reg         <= '0;
        end else begin
            lane_mode_reg    <= lane_mode_next;
            channel_size_reg <= channel_size_next;
            lanes_reg        <= lanes_next;
            size_reg         <= size_next;
            per_lane_reg     <= per_lane_next;
            full_reg         <= full_next;
            position_reg     <= position_next;
            pos_mod3_reg     <= pos_mod3_next;
            sums_reg         <= sums_next;
        end
    end

endmodule

FILE: rtl/gap_job_fifo.sv
// gap_job_fifo: short queue of finished-channel jobs between front and back.
// Depends on gap_pkg for job_t and JOB_DEPTH.
`timescale 1ns / 1ps

module gap_job_fifo
    import gap_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(JOB_DEPTH + 1);

    job_t               mem_reg [JOB_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W_Q-1:0] count_reg;

    assign full     = (count_reg == CNT_W_Q'(JOB_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W_Q'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W_Q'(1);
            end
        end
    end

endmodule

FILE: rtl/gap_back.sv
// gap_back: per-lane restoring divider and output register for channel averages.
// Depends on gap_pkg; reads jobs from gap_job_fifo and drives the result stream.
`timescale 1ns / 1ps

module gap_back
    import gap_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // job queue
    input  logic                empty,
    input  job_t                head_job,
    output logic                pop,
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata,
    output logic [LANE_W-1:0]   m_tuser,
    output logic                m_tlast
);

    back_state_t         state_reg, state_next;
    logic [LANE_W-1:0]   lane_reg, lane_next, lane_start;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [SUM_W-1:0]    dvd_reg, dvd_next;
    logic                neg_reg, neg_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] avg_reg;
    logic [LANE_W-1:0]   out_lane_reg;
    logic                out_last_reg;
    logic                load_out, is_last, per_zero, start_neg, ge;
    logic [SUM_W-1:0]    start_sum, start_mag;
    logic [CNT_W:0]      rem_sh, rem_diff;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = avg_reg;
    assign m_tuser  = out_lane_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        lane_start = (state_reg == B_HOLD) ? lane_reg + LANE_W'(1) : '0;
        start_sum  = head_job.sums[lane_start];
        start_neg  = start_sum[SUM_W-1];
        start_mag  = start_neg ? (~start_sum + SUM_W'(1)) : start_sum;
        per_zero   = (head_job.per_lane == '0);
        is_last    = ({1'b0, lane_reg} + LCNT_W'(1)) == head_job.lanes;

        // One quotient bit per cycle
        rem_sh   = {rem_reg, dvd_reg[SUM_W-1]};
        ge       = rem_sh >= {1'b0, head_job.per_lane};
        rem_diff = rem_sh - {1'b0, head_job.per_lane};

        state_next = state_reg;
        lane_next  = lane_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        neg_next   = neg_reg;
        step_next  = step_reg;
        pop        = 1'b0;
        load_out   = 1'b0;

        unique case (state_reg)
            B_IDLE: begin
                if (!empty) begin
                    lane_next  = lane_start;
                    rem_next   = '0;
                    step_next  = '0;
                    dvd_next   = per_zero ? '0 : start_mag;
                    neg_next   = per_zero ? 1'b0 : start_neg;
                    state_next = per_zero ? B_HOLD : B_DIV;
                end
            end
            B_DIV: begin
                rem_next  = ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                dvd_next  = {dvd_reg[SUM_W-2:0], ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    state_next = B_HOLD;
                end
            end
            B_HOLD: begin
                if (!out_valid_reg || m_tready) begin
                    load_out = 1'b1;
                    if (is_last) begin
                        pop        = 1'b1;
                        state_next = B_IDLE;
                    end else begin
                        lane_next  = lane_start;
                        rem_next   = '0;
                        step_next  = '0;
                        dvd_next   = per_zero ? '0 : start_mag;
                        neg_next   = per_zero ? 1'b0 : start_neg;
                        state_next = per_zero ? B_HOLD : B_DIV;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Divider datapath
    always_ff @(posedge aclk) begin
        lane_reg <= lane_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        neg_reg  <= neg_next;
        step_reg <= step_next;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (load_out) begin
            avg_reg      <= saturate_q(dvd_reg, neg_reg);
            out_lane_reg <= lane_reg;
            out_last_reg <= is_last;
        end
    end

endmodule

FILE: rtl/global_average_pool_unit.sv
// global_average_pool_unit: top level of the global average pool block.
// Depends on gap_pkg, gap_front, gap_job_fifo and gap_back.
//
//  Group   Dir  Signals                              Transaction
//  s_      in   s_tvalid/s_tready, s_tdata[15:0]     one sample (Q8.8)
//  m_      out  m_tvalid/m_tready, m_tdata, m_tuser  one lane average, m_tlast on final lane
//  cfg_    in   cfg_valid/cfg_ready, index, data     one register write
//
// The front takes one sample per cycle; it stalls whenever the two-entry job
// queue is full. The back divides each lane in 32 divider steps and then loads
// the output stage; a lane with a zero per-lane count skips the divider, and the
// back returns to idle after each channel; a full output register stalls it.
// Reset (aresetn low, synchronous) clears sums, position, queue and the output
// valid flag; configuration returns to one lane, channel size 1.
`timescale 1ns / 1ps

module global_average_pool_unit
    import gap_pkg::*;
#(
    parameter int MAX_CHANNEL_ELEMS = 65536,
    parameter int MAX_LANES         = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,   // [15:0] average
    output logic [LANE_W-1:0]     m_tuser,   // [1:0] lane
    output logic                  m_tlast
);

    logic push, pop, full, empty;
    job_t push_job, head_job;

    gap_front #(
        .MAX_CHANNEL_ELEMS(MAX_CHANNEL_ELEMS),
        .MAX_LANES        (MAX_LANES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .fifo_full(full),
        .push     (push),
        .push_job (push_job)
    );

    gap_job_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .head_job(head_job),
        .full    (full),
        .empty   (empty)
    );

    gap_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .empty   (empty),
        .head_job(head_job),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

FILE: test/global_average_pool_unit_test.sv
// global_average_pool_unit_test: self-checking bench for the global average pool unit.
// Streams samples under random bursts and output stalls, predicts each lane average.
// Depends on gap_pkg and global_average_pool_unit.
`timescale 1ns / 1ps

module global_average_pool_unit_test;
    import gap_pkg::*;

    localparam int MAX_CHANNEL_ELEMS = 65536;
    localparam int MAX_LANES         = 4;
    localparam int RANDOM_ITEMS      = 100;
    localparam int HOLD_CYCLES       = 600;
    localparam int SETTLE_CYCLES     = 200;
    localparam int REPORT_LIMIT      = 10;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic [LANE_W-1:0]   lane;
        logic                last;
    } lane_average_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;
    logic [LANE_W-1:0]     m_tuser;
    logic                  m_tlast;

    // Pending samples and expected averages
    logic [SAMPLE_W-1:0] pending_samples [$];
    lane_average_t       expected_averages [$];
    int unsigned         mismatch_count = 0;

    // Predictor state
    logic [1:0]            cur_mode = MODE_ONE;
    logic [CFG_DATA_W-1:0] cur_size = 1;
    logic [SUM_W-1:0]      acc_sums [LANE_SLOTS];
    int unsigned           sample_pos = 0;

    logic hold_armed = 1'b0;

    global_average_pool_unit #(
        .MAX_CHANNEL_ELEMS(MAX_CHANNEL_ELEMS),
        .MAX_LANES        (MAX_LANES)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [15:0] sample
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [15:0] average
        .m_tuser  (m_tuser),    // [1:0] lane
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    // Lane count and effective channel size under the current settings
    function automatic int unsigned lanes_now();
        int unsigned n;
        if (cur_mode == MODE_ONE) n = 1;
        else if (cur_mode == MODE_TWO) n = 2;
        else n = 4;
        return (n > MAX_LANES) ? MAX_LANES : n;
    endfunction

    function automatic int unsigned size_now();
        if (cur_size == 0) return 1;
        if (cur_size > MAX_CHANNEL_ELEMS) return MAX_CHANNEL_ELEMS;
        return cur_size;
    endfunction

    // Sum divided by the per-lane count, toward zero, clamped to 16 bits
    function automatic logic [SAMPLE_W-1:0] lane_quotient(input logic [SUM_W-1:0] sum,
                                                          input int unsigned count);
        longint q;
        if (count == 0) return '0;
        q = longint'($signed(sum)) / longint'(count);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[SAMPLE_W-1:0];
    endfunction

    // Fold one sample into the lane sums; close the channel on its last element
    task automatic accumulate_sample(input logic [SAMPLE_W-1:0] sample);
        int unsigned   lanes;
        int unsigned   size;
        int unsigned   per_lane;
        lane_average_t avg;
        lanes    = lanes_now();
        size     = size_now();
        per_lane = size / lanes;
        if (sample_pos < per_lane * lanes)
            acc_sums[sample_pos % lanes] = acc_sums[sample_pos % lanes]
                                           + {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
        if (sample_pos + 1 < size) begin
            sample_pos++;
        end else begin
            for (int k = 0; k < lanes; k++) begin
                avg.average = lane_quotient(acc_sums[k], per_lane);
                avg.lane    = LANE_W'(k);
                avg.last    = (k + 1 == lanes);
                expected_averages.push_back(avg);
            end
            for (int k = 0; k < LANE_SLOTS; k++) acc_sums[k] = '0;
            sample_pos = 0;
        end
    endtask

    // Monitor: register writes, accepted samples, and result checks
    always @(posedge aclk) begin
        lane_average_t got;
        lane_average_t want;
        if (!aresetn) begin
            cur_mode   = MODE_ONE;
            cur_size   = 1;
            sample_pos = 0;
            for (int k = 0; k < LANE_SLOTS; k++) acc_sums[k] = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_LANE_MODE) cur_mode = cfg_data[1:0];
                else if (cfg_index == REG_CHANNEL_SIZE) cur_size = cfg_data;
            end
            if (s_tvalid && s_tready) accumulate_sample(s_tdata);
            if (m_tvalid && m_tready) begin
                got.average = m_tdata;
                got.lane    = m_tuser;
                got.last    = m_tlast;
                if (expected_averages.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("unexpected result: average %0d lane %0d last %0d",
                                 $signed(got.average), got.lane, got.last);
                    mismatch_count++;
                end else begin
                    want = expected_averages.pop_front();
                    if (got.average !== want.average || got.lane !== want.lane ||
                        got.last !== want.last) begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display({"mismatch: expected average %0d lane %0d last %0d,",
                                      " got average %0d lane %0d last %0d"},
                                     $signed(want.average), want.lane, want.last,
                                     $signed(got.average), got.lane, got.last);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Sample driver: random bursts separated by random gaps
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else if (s_tvalid && !s_tready) begin
            // hold the offered transaction
        end else if (gap_left != 0) begin
            s_tvalid <= 1'b0;
            gap_left--;
        end else if (pending_samples.size() != 0) begin
            if (burst_left == 0) burst_left = $urandom_range(1, 24);
            s_tvalid <= 1'b1;
            s_tdata  <= pending_samples.pop_front();
            burst_left--;
            if (burst_left == 0)
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Result receiver: rotating stall pattern plus one long hold-off
    logic [7:0]  stall_phase;
    int unsigned hold_left;
    logic        hold_done;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_phase = '0;
            hold_left   = 0;
            hold_done   = 1'b0;
        end else if (hold_armed && !hold_done) begin
            m_tready <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            stall_phase++;
            case (stall_phase[7:6])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= (stall_phase[1:0] != 2'd0);
                2'd2: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic queue_samples(input int unsigned n);
        repeat (n) pending_samples.push_back(random_sample());
    endtask

    // One register write transaction; returns on a falling edge
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // All samples taken, all averages seen, then let the front settle
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || expected_averages.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Stimulus
    initial begin
        int unsigned random_items;
        int unsigned which;
        int unsigned pick;
        int unsigned new_size;
        int unsigned n;

        random_items = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);

        // Reset settings: one lane, one sample per channel
        pending_samples.push_back(16'h7FFF);
        pending_samples.push_back(16'h8000);
        pending_samples.push_back(16'h0000);
        pending_samples.push_back(16'hFFFF);
        wait_idle();

        // Four lanes, alternating extremes
        write_register(REG_LANE_MODE, 2);
        write_register(REG_CHANNEL_SIZE, 8);
        repeat (4) begin
            pending_samples.push_back(16'h7FFF);
            pending_samples.push_back(16'h8000);
        end
        wait_idle();

        // Lane mode three acts as four; channel shorter than the lanes gives zeros
        write_register(REG_LANE_MODE, 3);
        write_register(REG_CHANNEL_SIZE, 3);
        queue_samples(3);
        wait_idle();

        // Size zero acts as one; two lanes get no elements
        write_register(REG_LANE_MODE, 1);
        write_register(REG_CHANNEL_SIZE, 0);
        queue_samples(1);
        wait_idle();

        // Two lanes with a skipped tail; negative sum truncates toward zero
        write_register(REG_CHANNEL_SIZE, 5);
        pending_samples.push_back(16'hFFFF);
        pending_samples.push_back(16'h0001);
        pending_samples.push_back(16'hFFFE);
        pending_samples.push_back(16'h0002);
        pending_samples.push_back(16'h1234);
        wait_idle();

        // Largest size, then shrink mid-channel: next sample closes it
        write_register(REG_LANE_MODE, 0);
        write_register(REG_CHANNEL_SIZE, MAX_CHANNEL_ELEMS);
        queue_samples(3);
        wait_idle();
        write_register(REG_CHANNEL_SIZE, 2);
        queue_samples(1);
        wait_idle();

        // Size above the limit is clamped; a short run, then closed by a small size
        write_register(REG_CHANNEL_SIZE, (1 << CFG_DATA_W) - 1);
        queue_samples(2);
        wait_idle();
        write_register(REG_CHANNEL_SIZE, 1);
        queue_samples(1);
        wait_idle();

        // Long output hold-off while short channels keep arriving
        write_register(REG_LANE_MODE, 1);
        write_register(REG_CHANNEL_SIZE, 2);
        hold_armed <= 1'b1;
        queue_samples(24);
        wait_idle();

        // Random settings with whole channels and occasional partial ones
        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 16) new_size = $urandom_range(1, 12);
            else if (pick < 19) new_size = $urandom_range(13, 24);
            else new_size = 0;
            which = $urandom_range(0, 2);
            if (which != 1) write_register(REG_LANE_MODE, $urandom_range(0, 3));
            if (which != 0) write_register(REG_CHANNEL_SIZE, new_size);
            n = size_now() * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) n += $urandom_range(1, size_now());
            queue_samples(n);
            random_items += n;
            wait_idle();
        end

        if (mismatch_count == 0 && expected_averages.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
